[rtl/core/bpc_pkg.sv]
package bpc_pkg;

    localparam int unsigned WORD_W        = 32;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned CAUSE_W       = 3;

    localparam logic [WORD_W-1:0] BLOCK_BYTES_RESET = 32'd16;
    localparam logic [WORD_W-1:0] SHORT_LIMIT       = 32'd2;
    localparam logic [WORD_W-1:0] UNIFORM_LIMIT     = 32'd16;
    localparam int unsigned       ROT_BITS          = 3;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_OK      = 3'd0,
        CAUSE_SHORT   = 3'd1,
        CAUSE_LENGTH  = 3'd2,
        CAUSE_SUM     = 3'd3,
        CAUSE_UNIFORM = 3'd4
    } cause_t;

    typedef struct packed {
        logic   valid;
        logic   ok;
        cause_t cause;
    } verdict_t;

endpackage

[rtl/core/bpc_if.sv]
interface bpc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface bpc_verdict_if;
    logic       valid;
    logic       ready;
    logic       block_ok;
    logic [2:0] fail_cause;

    modport source (output valid, output block_ok, output fail_cause, input ready);
    modport sink   (input valid, input block_ok, input fail_cause, output ready);
endinterface

[rtl/core/bpc_core.sv]
module bpc_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [bpc_pkg::BYTE_W-1:0]    data_byte,
    input  logic [bpc_pkg::WORD_W-1:0]    block_bytes,
    output bpc_pkg::verdict_t             verdict
);
    import bpc_pkg::*;

    logic [WORD_W-1:0] pos_reg,        pos_next;
    logic [WORD_W-1:0] run_sum_reg,    run_sum_next;
    logic [WORD_W-1:0] stored_sum_reg, stored_sum_next;
    logic [WORD_W-1:0] stored_len_reg, stored_len_next;
    logic [BYTE_W-1:0] first_val_reg,  first_val_next;
    logic              all_equal_reg,  all_equal_next;

    logic              first_byte;
    logic              last_byte;
    logic [WORD_W-1:0] seed;
    logic [WORD_W-1:0] rotated;
    logic [WORD_W-1:0] updated_sum;
    cause_t            cause;

    always_comb
    begin
        first_byte = (pos_reg == '0);
        seed       = first_byte ? block_bytes : run_sum_reg;
        rotated    = {seed[WORD_W-ROT_BITS-1:0], seed[WORD_W-1:WORD_W-ROT_BITS]};

        first_val_next = first_byte ? data_byte : first_val_reg;
        all_equal_next = first_byte ? 1'b1 : (all_equal_reg && (data_byte == first_val_reg));

        // bytes 0..3 carry the checksum, 4..7 the length, both little-endian
        stored_sum_next = stored_sum_reg;
        stored_len_next = stored_len_reg;
        for (int i = 0; i < 4; i++)
        begin
            if (pos_reg[WORD_W-1:2] == '0 && pos_reg[1:0] == i[1:0])
                stored_sum_next[i*BYTE_W +: BYTE_W] = data_byte;
            if (pos_reg[WORD_W-1:3] == '0 && pos_reg[2] && pos_reg[1:0] == i[1:0])
                stored_len_next[i*BYTE_W +: BYTE_W] = data_byte;
        end

        if (|pos_reg[WORD_W-1:3])
            updated_sum = rotated + {{(WORD_W-BYTE_W){1'b0}}, data_byte};
        else
            updated_sum = seed;

        last_byte = ({1'b0, pos_reg} + 33'd1) >= {1'b0, block_bytes};

        if (block_bytes < SHORT_LIMIT)
            cause = CAUSE_SHORT;
        else if (block_bytes < UNIFORM_LIMIT)
            cause = all_equal_next ? CAUSE_OK : CAUSE_UNIFORM;
        else if (stored_len_next != block_bytes)
            cause = CAUSE_LENGTH;
        else if (stored_sum_next != updated_sum)
            cause = CAUSE_SUM;
        else
            cause = CAUSE_OK;

        // restart position and reseed at the end of each block
        pos_next     = last_byte ? '0 : pos_reg + 32'd1;
        run_sum_next = last_byte ? block_bytes : updated_sum;

        verdict.valid = advance && last_byte;
        verdict.ok    = (cause == CAUSE_OK);
        verdict.cause = cause;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            run_sum_reg    <= BLOCK_BYTES_RESET;
            stored_sum_reg <= '0;
            stored_len_reg <= '0;
            first_val_reg  <= '0;
            all_equal_reg  <= 1'b1;
        end
        else if (advance)
        begin
            pos_reg        <= pos_next;
            run_sum_reg    <= run_sum_next;
            stored_sum_reg <= stored_sum_next;
            stored_len_reg <= stored_len_next;
            first_val_reg  <= first_val_next;
            all_equal_reg  <= all_equal_next;
        end
    end

endmodule

[rtl/core/block_pattern_checker.sv]
// Streaming checker for fixed-length data blocks, one byte per transaction on
// byte_stream, one verdict transaction on verdict at the last byte of each
// block (block_ok plus fail_cause). It sustains one byte per clock unless a
// verdict is held back by verdict.ready low; each byte passes the input
// register and the combinational checksum update (rotate left by 3, add,
// compare) into the result register. Write block_bytes only while no block
// is in flight; the block length in use is always the last value written.
module block_pattern_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          block_bytes_we,
    input  logic [bpc_pkg::WORD_W-1:0]    block_bytes_wdata,
    bpc_byte_if.sink                      byte_stream,
    bpc_verdict_if.source                 verdict
);
    import bpc_pkg::*;

    logic [WORD_W-1:0]  block_bytes_reg;
    logic               in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]  in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg;
    logic [CAUSE_W-1:0] out_cause_reg;

    logic               advance;
    logic               accept;
    verdict_t           result;

    bpc_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .data_byte   (in_byte_reg),
        .block_bytes (block_bytes_reg),
        .verdict     (result)
    );

    always_comb
    begin
        // process the held byte whenever the result slot is free or draining
        advance           = in_valid_reg && (!out_valid_reg || verdict.ready);
        byte_stream.ready = !in_valid_reg || advance;
        accept            = byte_stream.valid && byte_stream.ready;

        in_valid_next = accept || (in_valid_reg && !advance);

        if (advance)
            out_valid_next = result.valid;
        else
            out_valid_next = out_valid_reg && !verdict.ready;

        verdict.valid      = out_valid_reg;
        verdict.block_ok   = out_ok_reg;
        verdict.fail_cause = out_cause_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_bytes_reg <= BLOCK_BYTES_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (block_bytes_we)
                block_bytes_reg <= block_bytes_wdata;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= byte_stream.data_byte;
        if (advance && result.valid)
        begin
            out_ok_reg    <= result.ok;
            out_cause_reg <= result.cause;
        end
    end

endmodule
